### rtl/bpc_pkg.sv
// Shared types, constants and helpers for the barometric pressure compensation block.
// Used by bpc_div, the top level and the checker; depends on nothing.
package bpc_pkg;

    localparam int WORD_W  = 32;
    localparam int SHIFT_W = 5;
    localparam int TEMP_W  = 28;
    localparam int UT_W    = 16;
    localparam int UP_W    = 19;
    localparam int COEF_W  = 16;
    localparam int SIDE_W  = 53;
    localparam int DIV_BITS = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_AC_1    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_AC_2    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BM      = 2'd3;

    localparam logic [WORD_W-1:0] B6_OFFSET   = 32'd4000;
    localparam logic [WORD_W-1:0] K_SQUARE    = 32'd3038;
    localparam logic [WORD_W-1:0] K_LINEAR    = 32'hFFFF_E343; // -7357
    localparam logic [WORD_W-1:0] K_OFFSET    = 32'd3791;
    localparam logic [WORD_W-1:0] B7_SCALE    = 32'd50000;
    localparam logic [WORD_W-1:0] X3_BIAS     = 32'd32768;

    typedef logic [WORD_W-1:0] word_t;

    function automatic word_t asr32(input word_t v, input logic [SHIFT_W-1:0] s);
        return word_t'($signed(v) >>> s);
    endfunction

    function automatic word_t sx16(input logic [COEF_W-1:0] v);
        return {{(WORD_W-COEF_W){v[COEF_W-1]}}, v};
    endfunction

    function automatic word_t zx16(input logic [COEF_W-1:0] v);
        return {{(WORD_W-COEF_W){1'b0}}, v};
    endfunction

endpackage

### rtl/barometric_pressure_compensation_top.sv
// Top level of the barometric pressure compensation pipeline.
// Depends on bpc_pkg and bpc_div.
//
// Usage: raw readings arrive on the s_ stream (raw temperature and raw
// pressure in s_tdata), results leave on the m_ stream (temperature in
// tenths of a degree and pressure in pascals in m_tdata, the divide error
// flag in m_tuser). Coefficients and oversampling are written through the
// cfg_ port, which is always ready; write only while no reading is in flight.
// Throughput is one reading per cycle: the datapath is a chain of register
// stages, including two 32-stage divider pipelines, one quotient bit each.
// The whole chain advances together; when a result waits on m_tready low,
// every stage holds and s_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits and all configuration registers to zero.
// A zero divisor in either division forces both results to zero and sets
// the error flag.
module barometric_pressure_compensation_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]     s_tdata,  // raw_temperature, raw_pressure
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0]    m_tdata,  // temperature_deci_c, pressure_pa
    output logic                              m_tuser,  // divide_error
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef bpc_pkg::word_t word_t;

    logic        en;
    logic [1:0]  ovs_reg;
    logic [47:0] cac1_reg;
    logic [47:0] cac2_reg;
    logic [63:0] cbm_reg;

    word_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, b7_scale;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovs_reg  <= '0;
            cac1_reg <= '0;
            cac2_reg <= '0;
            cbm_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bpc_pkg::REG_OVERSAMPLING: ovs_reg  <= cfg_data[1:0];
                bpc_pkg::REG_COEF_AC_1:    cac1_reg <= cfg_data[47:0];
                bpc_pkg::REG_COEF_AC_2:    cac2_reg <= cfg_data[47:0];
                bpc_pkg::REG_COEF_BM:      cbm_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ac1 = bpc_pkg::sx16(cac1_reg[47:32]);
        ac2 = bpc_pkg::sx16(cac1_reg[31:16]);
        ac3 = bpc_pkg::sx16(cac1_reg[15:0]);
        ac4 = bpc_pkg::zx16(cac2_reg[47:32]);
        ac5 = bpc_pkg::zx16(cac2_reg[31:16]);
        ac6 = bpc_pkg::zx16(cac2_reg[15:0]);
        b1  = bpc_pkg::sx16(cbm_reg[63:48]);
        b2  = bpc_pkg::sx16(cbm_reg[47:32]);
        mc  = bpc_pkg::sx16(cbm_reg[31:16]);
        md  = bpc_pkg::sx16(cbm_reg[15:0]);
        b7_scale = bpc_pkg::B7_SCALE >> ovs_reg;
    end

    // Temperature front end.
    logic                      v1_reg, v2_reg, v3_reg;
    logic [bpc_pkg::UT_W-1:0]  ut1_reg;
    logic [bpc_pkg::UP_W-1:0]  up1_reg, up2_reg, up3_reg;
    word_t                     d2_reg, x1_3_reg, div1_3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ut1_reg    <= s_tdata[15:0];
            up1_reg    <= s_tdata[34:16];
            d2_reg     <= bpc_pkg::zx16(ut1_reg) - ac6;
            up2_reg    <= up1_reg;
            x1_3_reg   <= bpc_pkg::asr32(word_t'(d2_reg * ac5), 5'd15);
            div1_3_reg <= bpc_pkg::asr32(word_t'(d2_reg * ac5), 5'd15) + md;
            up3_reg    <= up2_reg;
        end
    end

    // First division: (mc << 11) / (x1 + md), signed, on magnitudes.
    word_t                     dn_a, dn_b, mag_a, mag_b;
    logic                      neg_q, err1;
    logic [bpc_pkg::SIDE_W-1:0] side1_in, side1_out;
    logic                      dv1_valid;
    word_t                     dv1_q;

    always_comb begin
        dn_a  = mc << 11;
        dn_b  = div1_3_reg;
        mag_a = dn_a[31] ? (32'd0 - dn_a) : dn_a;
        mag_b = dn_b[31] ? (32'd0 - dn_b) : dn_b;
        neg_q = dn_a[31] ^ dn_b[31];
        err1  = (dn_b == 32'd0);
        side1_in = {err1, neg_q, up3_reg, x1_3_reg};
    end

    bpc_div u_div_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .dividend  (mag_a),
        .divisor   (mag_b),
        .side_in   (side1_in),
        .out_valid (dv1_valid),
        .quotient  (dv1_q),
        .side_out  (side1_out)
    );

    // Temperature result and pressure coefficient chain.
    logic  v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg, v11_reg;
    logic  e5_reg, e6_reg, e7_reg, e8_reg, e9_reg, e10_reg, e11_reg;
    logic [bpc_pkg::UP_W-1:0] up5_reg, up6_reg, up7_reg, up8_reg, up9_reg;
    logic [bpc_pkg::TEMP_W-1:0] t6_reg, t7_reg, t8_reg, t9_reg, t10_reg, t11_reg;
    word_t b5_reg, b6_reg;
    word_t sqf_reg, pac2_reg, pac3_reg;
    word_t mb2_reg, mb1_reg, xa2_reg, xa3_reg;
    word_t b3_reg, x3p_reg;
    word_t b4f_reg, diff_reg;
    word_t b4_reg, b7_reg;
    word_t x2_5, tv6, tq6, sq8, x1_9, x2_9, b3_9, x3_9;

    always_comb begin
        x2_5 = side1_out[51] ? (32'd0 - dv1_q) : dv1_q;
        tv6  = b5_reg + 32'd8;
        tq6  = tv6[31] ? bpc_pkg::asr32(tv6 + 32'd15, 5'd4) : bpc_pkg::asr32(tv6, 5'd4);
        sq8  = bpc_pkg::asr32(sqf_reg, 5'd12);
        x1_9 = bpc_pkg::asr32(mb2_reg, 5'd11);
        x2_9 = bpc_pkg::asr32(mb1_reg, 5'd16);
        b3_9 = bpc_pkg::asr32((((ac1 << 2) + x1_9 + xa2_reg) << ovs_reg) + 32'd2, 5'd2);
        x3_9 = bpc_pkg::asr32(xa3_reg + x2_9 + 32'd2, 5'd2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end else if (en) begin
            v5_reg  <= dv1_valid;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b5_reg   <= side1_out[31:0] + x2_5;
            up5_reg  <= side1_out[50:32];
            e5_reg   <= side1_out[52];

            t6_reg   <= tq6[bpc_pkg::TEMP_W-1:0];
            b6_reg   <= b5_reg - bpc_pkg::B6_OFFSET;
            up6_reg  <= up5_reg;
            e6_reg   <= e5_reg;

            sqf_reg  <= word_t'(b6_reg * b6_reg);
            pac2_reg <= word_t'(ac2 * b6_reg);
            pac3_reg <= word_t'(ac3 * b6_reg);
            t7_reg   <= t6_reg;
            up7_reg  <= up6_reg;
            e7_reg   <= e6_reg;

            mb2_reg  <= word_t'(b2 * sq8);
            mb1_reg  <= word_t'(b1 * sq8);
            xa2_reg  <= bpc_pkg::asr32(pac2_reg, 5'd11);
            xa3_reg  <= bpc_pkg::asr32(pac3_reg, 5'd13);
            t8_reg   <= t7_reg;
            up8_reg  <= up7_reg;
            e8_reg   <= e7_reg;

            b3_reg   <= b3_9;
            x3p_reg  <= x3_9 + bpc_pkg::X3_BIAS;
            t9_reg   <= t8_reg;
            up9_reg  <= up8_reg;
            e9_reg   <= e8_reg;

            b4f_reg  <= word_t'(ac4 * x3p_reg);
            diff_reg <= {13'd0, up9_reg} - b3_reg;
            t10_reg  <= t9_reg;
            e10_reg  <= e9_reg;

            b4_reg   <= b4f_reg >> 15;
            b7_reg   <= word_t'(diff_reg * b7_scale);
            t11_reg  <= t10_reg;
            e11_reg  <= e10_reg;
        end
    end

    // Second division: b7 scaled by two (unscaled when its top bit is set), over b4, unsigned.
    logic                       b7_hi, err2;
    word_t                      dn2;
    logic [bpc_pkg::SIDE_W-1:0] side2_in, side2_out;
    logic                       dv2_valid;
    word_t                      dv2_q;

    always_comb begin
        b7_hi    = b7_reg[31];
        dn2      = b7_hi ? b7_reg : (b7_reg << 1);
        err2     = e11_reg || (b4_reg == 32'd0);
        side2_in = {23'd0, b7_hi, err2, t11_reg};
    end

    bpc_div u_div_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v11_reg),
        .dividend  (dn2),
        .divisor   (b4_reg),
        .side_in   (side2_in),
        .out_valid (dv2_valid),
        .quotient  (dv2_q),
        .side_out  (side2_out)
    );

    // Final pressure polynomial.
    logic  v13_reg, v14_reg, v15_reg, v16_reg;
    logic  e13_reg, e14_reg, e15_reg, e16_reg;
    logic [bpc_pkg::TEMP_W-1:0] t13_reg, t14_reg, t15_reg, t16_reg;
    word_t p13_reg, p14_reg, p15_reg, comp16_reg;
    word_t psq14_reg, x2m14_reg, x1m15_reg, x2_15_reg;
    word_t ps13, x1_16, comp16;

    always_comb begin
        ps13   = bpc_pkg::asr32(p13_reg, 5'd8);
        x1_16  = bpc_pkg::asr32(x1m15_reg, 5'd16);
        comp16 = p15_reg + bpc_pkg::asr32(x1_16 + x2_15_reg + bpc_pkg::K_OFFSET, 5'd4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
            v15_reg <= 1'b0;
            v16_reg <= 1'b0;
        end else if (en) begin
            v13_reg <= dv2_valid;
            v14_reg <= v13_reg;
            v15_reg <= v14_reg;
            v16_reg <= v15_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // A large b7 was divided unscaled, so its quotient is doubled here.
            p13_reg    <= side2_out[29] ? (dv2_q << 1) : dv2_q;
            t13_reg    <= side2_out[27:0];
            e13_reg    <= side2_out[28];

            psq14_reg  <= word_t'(ps13 * ps13);
            x2m14_reg  <= word_t'(bpc_pkg::K_LINEAR * p13_reg);
            p14_reg    <= p13_reg;
            t14_reg    <= t13_reg;
            e14_reg    <= e13_reg;

            x1m15_reg  <= word_t'(psq14_reg * bpc_pkg::K_SQUARE);
            x2_15_reg  <= bpc_pkg::asr32(x2m14_reg, 5'd16);
            p15_reg    <= p14_reg;
            t15_reg    <= t14_reg;
            e15_reg    <= e14_reg;

            comp16_reg <= e15_reg ? 32'd0 : comp16;
            t16_reg    <= e15_reg ? '0 : t15_reg;
            e16_reg    <= e15_reg;
        end
    end

    assign m_tvalid = v16_reg;
    assign m_tdata  = {4'd0, comp16_reg, t16_reg};
    assign m_tuser  = e16_reg;

endmodule

### rtl/bpc_div.sv
// Pipelined unsigned 32-by-32 restoring divider, one quotient bit per stage.
// Carries a sideband word and a valid bit alongside; depends on bpc_pkg.
module bpc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  bpc_pkg::word_t              dividend,
    input  bpc_pkg::word_t              divisor,
    input  logic [bpc_pkg::SIDE_W-1:0]  side_in,
    output logic                        out_valid,
    output bpc_pkg::word_t              quotient,
    output logic [bpc_pkg::SIDE_W-1:0]  side_out
);

    bpc_pkg::word_t              rem_reg  [bpc_pkg::DIV_BITS+1];
    bpc_pkg::word_t              num_reg  [bpc_pkg::DIV_BITS+1];
    bpc_pkg::word_t              den_reg  [bpc_pkg::DIV_BITS+1];
    logic [bpc_pkg::SIDE_W-1:0]  side_reg [bpc_pkg::DIV_BITS+1];
    logic [bpc_pkg::DIV_BITS:0]  vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            num_reg[0]  <= dividend;
            den_reg[0]  <= divisor;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < bpc_pkg::DIV_BITS; k++) begin : g_stage
        logic [bpc_pkg::WORD_W:0]   shifted;
        logic [bpc_pkg::WORD_W+1:0] trial;
        logic                       qbit;
        bpc_pkg::word_t             rem_next;

        always_comb begin
            shifted  = {rem_reg[k], num_reg[k][bpc_pkg::WORD_W-1]};
            trial    = {1'b0, shifted} - {2'b00, den_reg[k]};
            qbit     = ~trial[bpc_pkg::WORD_W+1];
            rem_next = qbit ? trial[bpc_pkg::WORD_W-1:0] : shifted[bpc_pkg::WORD_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                num_reg[k+1]  <= {num_reg[k][bpc_pkg::WORD_W-2:0], qbit};
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[bpc_pkg::DIV_BITS];
    assign quotient  = num_reg[bpc_pkg::DIV_BITS];
    assign side_out  = side_reg[bpc_pkg::DIV_BITS];

endmodule

### rtl/bpc_checker.sv
// Port-level checks for the barometric pressure compensation top level.
// Depends on bpc_pkg; attached to the top level by the bind at the end.
module bpc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bpc_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    // A stalled result transaction keeps its valid and payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A divide error always comes with zeroed results.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("divide error with nonzero results");

    // The input side is ready exactly when the output side can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // Nothing comes out in the first cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (.*);

### test/tb_barometric_pressure_compensation_top.sv
// Self-checking testbench for barometric_pressure_compensation_top.
// Predicts each compensated temperature/pressure reading in SystemVerilog and
// checks it against the m_ stream under random idling and backpressure; needs bpc_pkg.
module tb_barometric_pressure_compensation_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 120;

    typedef bit [31:0] u32_t;
    typedef struct packed {
        bit [bpc_pkg::TEMP_W-1:0] temp_deci_c;
        u32_t                     pressure_pa;
        bit                       div_error;
    } reading_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [bpc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the calibration registers.
    bit [1:0]  os_mode;
    bit [47:0] coef_ac_signed;
    bit [47:0] coef_ac_unsigned;
    bit [63:0] coef_bm;

    reading_t pending_readings[$];
    int       fail_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_len = 0;
    int       quiet_cycles = 0;

    barometric_pressure_compensation_top dut (.*);

    always #4 aclk = ~aclk;

    function automatic u32_t shr_arith(u32_t v, int s);
        return u32_t'($signed(v) >>> s);
    endfunction

    // Truncating signed division on 32-bit patterns; min / -1 stays min.
    function automatic u32_t div_trunc(u32_t a, u32_t b);
        u32_t ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic u32_t s16(bit [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic reading_t compensate(bit [bpc_pkg::UT_W-1:0] ut,
                                            bit [bpc_pkg::UP_W-1:0] up);
        u32_t ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        u32_t x1, x2, x3, div1, b5, t, b6, sq, b3, b4, b7, p, ps;
        reading_t r;
        ac1 = s16(coef_ac_signed[47:32]);
        ac2 = s16(coef_ac_signed[31:16]);
        ac3 = s16(coef_ac_signed[15:0]);
        ac4 = {16'd0, coef_ac_unsigned[47:32]};
        ac5 = {16'd0, coef_ac_unsigned[31:16]};
        ac6 = {16'd0, coef_ac_unsigned[15:0]};
        b1 = s16(coef_bm[63:48]);
        b2 = s16(coef_bm[47:32]);
        mc = s16(coef_bm[31:16]);
        md = s16(coef_bm[15:0]);
        r = '{temp_deci_c: '0, pressure_pa: '0, div_error: 1'b1};
        x1 = shr_arith((u32_t'(ut) - ac6) * ac5, 15);
        div1 = x1 + md;
        if (div1 == 0) return r;
        x2 = div_trunc(mc << 11, div1);
        b5 = x1 + x2;
        t = div_trunc(b5 + 32'd8, 32'd16);
        b6 = b5 - 32'd4000;
        sq = shr_arith(b6 * b6, 12);
        x1 = shr_arith(b2 * sq, 11);
        x2 = shr_arith(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = shr_arith(((ac1 * 32'd4 + x3) << os_mode) + 32'd2, 2);
        x1 = shr_arith(ac3 * b6, 13);
        x2 = shr_arith(b1 * sq, 16);
        x3 = shr_arith(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = (u32_t'(up) - b3) * (32'd50000 >> os_mode);
        p = !b7[31] ? (b7 << 1) / b4 : (b7 / b4) << 1;
        ps = shr_arith(p, 8);
        x1 = shr_arith((ps * ps) * 32'd3038, 16);
        x2 = shr_arith(-32'd7357 * p, 16);
        r.pressure_pa = p + shr_arith(x1 + x2 + 32'd3791, 4);
        r.temp_deci_c = t[bpc_pkg::TEMP_W-1:0];
        r.div_error = 1'b0;
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off when hold_len is loaded.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_len > 0) begin
            m_tready <= 1'b0;
            hold_len <= hold_len - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_readings.size() == 0) begin
                $error("unexpected result transaction: tdata=%h tuser=%b", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_tdata[bpc_pkg::TEMP_W-1:0] !== want.temp_deci_c) begin
                    $error("temperature_deci_c: expected %0d, got %0d",
                           $signed(want.temp_deci_c), $signed(m_tdata[bpc_pkg::TEMP_W-1:0]));
                    fail_count++;
                end
                if (m_tdata[bpc_pkg::TEMP_W +: 32] !== want.pressure_pa) begin
                    $error("pressure_pa: expected %0d, got %0d",
                           $signed(want.pressure_pa), $signed(m_tdata[bpc_pkg::TEMP_W +: 32]));
                    fail_count++;
                end
                if (m_tuser !== want.div_error) begin
                    $error("divide_error: expected %0b, got %0b", want.div_error, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_barometric_pressure_compensation_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_reading(bit [bpc_pkg::UT_W-1:0] ut, bit [bpc_pkg::UP_W-1:0] up);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(bpc_pkg::IN_DATA_W-bpc_pkg::UT_W-bpc_pkg::UP_W){1'b0}}, up, ut};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_readings.push_back(compensate(ut, up));
    endtask

    // Lower valid and let every outstanding reading come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bpc_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        unique case (idx)
            bpc_pkg::REG_OVERSAMPLING: os_mode = value[1:0];
            bpc_pkg::REG_COEF_AC_1:    coef_ac_signed = value[47:0];
            bpc_pkg::REG_COEF_AC_2:    coef_ac_unsigned = value[47:0];
            bpc_pkg::REG_COEF_BM:      coef_bm = value;
        endcase
    endtask

    task automatic load_calibration(bit [1:0] oss, bit [47:0] ac_s, bit [47:0] ac_u,
                                    bit [63:0] bm);
        drain_results();
        write_register(bpc_pkg::REG_OVERSAMPLING, {$urandom, $urandom} & ~64'h3 | oss);
        write_register(bpc_pkg::REG_COEF_AC_1, {16'd0, ac_s});
        write_register(bpc_pkg::REG_COEF_AC_2, {16'd0, ac_u});
        write_register(bpc_pkg::REG_COEF_BM, bm);
    endtask

    // Typical factory coefficients, optionally nudged at random.
    task automatic load_typical(bit [1:0] oss, int jitter);
        bit [15:0] c[11];
        c = '{16'd408, -16'sd72, -16'sd14383, 16'd32741, 16'd32757, 16'd23153,
              16'd6190, 16'd4, -16'sd8711, 16'd2868, 16'd0};
        foreach (c[i]) c[i] = c[i] + 16'($urandom_range(2 * jitter) - jitter);
        load_calibration(oss, {c[0], c[1], c[2]}, {c[3], c[4], c[5]},
                         {c[6], c[7], c[8], c[9]});
    endtask

    task automatic send_random(int n);
        repeat (n) send_reading(16'($urandom), 19'($urandom));
    endtask

    task automatic test_reset_defaults();
        // All-zero coefficients give a zero temperature divisor.
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'd27898, 19'd23843);
    endtask

    task automatic test_typical_reading();
        load_typical(2'd0, 0);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        send_reading(16'd23153, 19'd40000);
        load_typical(2'd3, 0);
        send_reading(16'd27898, 19'd190744);
        send_reading(16'hFFFF, 19'd0);
    endtask

    task automatic test_divide_errors();
        // Zero temperature divisor: ac5 = 0 makes x1 zero, md = 0.
        load_calibration(2'd1, 48'h0198_FFB8_C7D1, 48'h7FE5_0000_5A71, 64'h182E_0004_DDF9_0000);
        send_reading(16'd27898, 19'd23843);
        // Zero pressure divisor: ac4 = 0.
        load_calibration(2'd2, 48'h0198_FFB8_C7D1, 48'h0000_7FF5_5A71, 64'h182E_0004_DDF9_0B34);
        send_reading(16'd27898, 19'd23843);
        send_reading(16'd0, 19'h7FFFF);
    endtask

    task automatic test_extremes();
        load_calibration(2'd3, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_reading(16'd0, 19'd0);
        send_reading(16'hFFFF, 19'h7FFFF);
        load_calibration(2'd0, 48'h8000_8000_8000, 48'hFFFF_FFFF_0000, 64'h8000_8000_8000_8000);
        send_reading(16'hFFFF, 19'd0);
        send_reading(16'd0, 19'h7FFFF);
        load_calibration(2'd2, 48'h7FFF_7FFF_7FFF, 48'h8000_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF);
        send_reading(16'h8000, 19'h40000);
        send_reading(16'h7FFF, 19'h3FFFF);
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        load_typical(2'($urandom), 200);
        send_random(70);
        load_calibration(2'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom});
        send_random(70);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_typical(2'd1, 50);
        hold_len = 400;
        send_random(120);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_typical_reading();
        test_divide_errors();
        test_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(76, 0);
        test_random_traffic(0, 76);
        test_random_traffic(14, 14);
        test_backpressure();
        drain_results();
        if (fail_count == 0) begin
            $display("tb_barometric_pressure_compensation_top passed");
        end else begin
            $display("tb_barometric_pressure_compensation_top failed");
        end
        $finish;
    end
endmodule
